// ----- hw/rtl/sh3_pkg.sv -----
package sh3_pkg;

	localparam int SAMPLE_W = 8;
	localparam int WIDTH_W  = 12;
	localparam int HEIGHT_W = 13;
	localparam int CHANS_W  = 3;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [CHANS_W-1:0]  CHANS_RST  = 3'd1;

	localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = 12'd3;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 13'd3;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;

	localparam int CENTRE_GAIN = 5;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_CHANS  = 2'd2
	} reg_idx_t;

	// effective (range-limited) frame geometry plus a restart strobe on any register write
	typedef struct packed {
		logic [WIDTH_W-1:0]  width;
		logic [HEIGHT_W-1:0] height;
		logic [CHANS_W-1:0]  chans;
		logic                restart;
	} sh3_cfg_t;

endpackage

// ----- hw/rtl/sh3_if.sv -----
interface sh3_in_if;
	logic                         valid;
	logic                         ready;
	logic [sh3_pkg::SAMPLE_W-1:0] sample;
	logic                         drain;

	modport source(output valid, sample, drain, input ready);
	modport sink(input valid, sample, drain, output ready);
endinterface

interface sh3_out_if;
	logic                         valid;
	logic                         ready;
	logic [sh3_pkg::SAMPLE_W-1:0] sharpened;
	logic                         last_of_frame;

	modport source(output valid, sharpened, last_of_frame, input ready);
	modport sink(input valid, sharpened, last_of_frame, output ready);
endinterface

// ----- hw/rtl/sh3_apb_regs.sv -----
module sh3_apb_regs #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sh3_pkg::APB_AW-1:0] paddr,
	input  logic [sh3_pkg::APB_DW-1:0] pwdata,
	output logic [sh3_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output sh3_pkg::sh3_cfg_t          cfg
);

	logic [sh3_pkg::WIDTH_W-1:0]  width_q;
	logic [sh3_pkg::HEIGHT_W-1:0] height_q;
	logic [sh3_pkg::CHANS_W-1:0]  chans_q;
	sh3_pkg::reg_idx_t            idx;
	logic                         wr_en;

	assign pready = 1'b1;
	assign idx    = sh3_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sh3_pkg::WIDTH_RST;
			height_q <= sh3_pkg::HEIGHT_RST;
			chans_q  <= sh3_pkg::CHANS_RST;
		end else if (wr_en) begin
			case (idx)
				sh3_pkg::REG_WIDTH:  width_q  <= pwdata[sh3_pkg::WIDTH_W-1:0];
				sh3_pkg::REG_HEIGHT: height_q <= pwdata[sh3_pkg::HEIGHT_W-1:0];
				sh3_pkg::REG_CHANS:  chans_q  <= pwdata[sh3_pkg::CHANS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sh3_pkg::REG_WIDTH:  prdata = {{(sh3_pkg::APB_DW-sh3_pkg::WIDTH_W){1'b0}}, width_q};
			sh3_pkg::REG_HEIGHT: prdata = {{(sh3_pkg::APB_DW-sh3_pkg::HEIGHT_W){1'b0}}, height_q};
			sh3_pkg::REG_CHANS:  prdata = {{(sh3_pkg::APB_DW-sh3_pkg::CHANS_W){1'b0}}, chans_q};
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		cfg.width = width_q;
		if (width_q < sh3_pkg::WIDTH_MIN) begin
			cfg.width = sh3_pkg::WIDTH_MIN;
		end else if (int'(width_q) > MAX_WIDTH) begin
			cfg.width = sh3_pkg::WIDTH_W'(MAX_WIDTH);
		end

		cfg.height = height_q;
		if (height_q < sh3_pkg::HEIGHT_MIN) begin
			cfg.height = sh3_pkg::HEIGHT_MIN;
		end else if (height_q > sh3_pkg::HEIGHT_MAX) begin
			cfg.height = sh3_pkg::HEIGHT_MAX;
		end

		cfg.chans = chans_q;
		if (chans_q == '0) begin
			cfg.chans = sh3_pkg::CHANS_W'(1);
		end else if (int'(chans_q) > MAX_CHANNELS) begin
			cfg.chans = sh3_pkg::CHANS_W'(MAX_CHANNELS);
		end

		case (idx)
			sh3_pkg::REG_WIDTH, sh3_pkg::REG_HEIGHT, sh3_pkg::REG_CHANS: cfg.restart = wr_en;
			default: cfg.restart = 1'b0;
		endcase
	end

endmodule

// ----- hw/rtl/sharpen_3x3_line_buffer_unit.sv -----
// channel   role   payload                      transaction when
// in_ch     sink   sample[7:0], drain           in_ch.valid & in_ch.ready
// out_ch    source sharpened[7:0], last_of_frame out_ch.valid & out_ch.ready
// apb       slave  width, height, channel_count psel & penable & pwrite
//
// One sample per clock sustained while out_ch is ready. A sample is accepted
// into the line-store read (stage 0), the kernel is evaluated on the registered
// read data (stage 1) and the result lands in the output register (out_ch.valid).
// The middle store has two read ports (centre and right neighbor) and one write.
// Reset clears counters, handshake state and config registers, not the line stores.
// A stalled output holds stage 1, and in_ch.ready drops only while both are full.
module sharpen_3x3_line_buffer_unit #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sh3_pkg::APB_AW-1:0] paddr,
	input  logic [sh3_pkg::APB_DW-1:0] pwdata,
	output logic [sh3_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	sh3_in_if.sink                     in_ch,
	sh3_out_if.source                  out_ch
);

	localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DIW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int SW    = sh3_pkg::SAMPLE_W;
	localparam int RW    = sh3_pkg::HEIGHT_W;
	localparam int KW    = SW + 4;

	typedef struct packed {
		logic is_sample;
		logic has_out;
		logic interior;
		logic last;
	} s1_flags_t;

	sh3_pkg::sh3_cfg_t cfg;

	sh3_apb_regs #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	logic [SW-1:0] upper_mem [DEPTH];
	logic [SW-1:0] mid_mem   [DEPTH];

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] len;
	logic [CW-1:0] n;
	logic [CW-1:0] c;
	logic [AW-1:0] a_c;
	logic [AW-1:0] a_cn;
	logic          last_col;
	logic          draining;
	logic          in_fire;
	logic          is_sample;
	logic          drain_out;
	logic          mem_rd;

	logic          valid_s1;
	s1_flags_t     flags_s1;
	logic [SW-1:0] sample_s1;
	logic [AW-1:0] addr_s1;
	logic          s1_adv;

	logic [SW-1:0] up_rd;
	logic [SW-1:0] mid_rd;
	logic [SW-1:0] right_rd;
	logic [SW-1:0] dly_q [MAX_CHANNELS];
	logic [SW-1:0] left;

	logic [KW-1:0]        centre5;
	logic [KW-1:0]        nsum;
	logic signed [KW-1:0] diff;
	logic [SW-1:0]        sat;

	logic          out_valid_q;
	logic [SW-1:0] sharpened_q;
	logic          last_q;

	assign len = CW'({{sh3_pkg::CHANS_W{1'b0}}, cfg.width} *
		{{sh3_pkg::WIDTH_W{1'b0}}, cfg.chans});
	assign n        = CW'(cfg.chans);
	assign c        = (col_q >= len) ? '0 : col_q;
	assign last_col = (c == len - 1'b1);
	assign a_c      = c[AW-1:0];
	assign a_cn     = AW'(c + n);
	assign draining = (row_q >= cfg.height);

	assign in_fire   = in_ch.valid & in_ch.ready;
	assign is_sample = !draining && !in_ch.drain;
	assign drain_out = draining && in_ch.drain;
	assign mem_rd    = in_fire && is_sample;

	assign s1_adv      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (is_sample) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= c + 1'b1;
				end
			end else if (drain_out) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= '0;
				end else begin
					col_q <= c + 1'b1;
				end
			end
		end
	end

	// read-first: a read and a write to the same entry in one cycle return the old data
	always_ff @(posedge clk) begin
		if (mem_rd) begin
			up_rd        <= upper_mem[a_c];
			mid_rd       <= mid_mem[a_c];
			right_rd     <= mid_mem[a_cn];
			mid_mem[a_c] <= in_ch.sample;
		end
		if (s1_adv && flags_s1.is_sample) begin
			upper_mem[addr_s1] <= mid_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1          <= in_ch.sample;
			addr_s1            <= a_c;
			flags_s1.is_sample <= is_sample;
			flags_s1.has_out   <= drain_out || (is_sample && row_q != '0);
			flags_s1.interior  <= is_sample && (row_q >= RW'(2)) && (c >= n) && (c < len - n);
			flags_s1.last      <= drain_out && last_col;
		end
	end

	// centre samples of the middle row, newest first; left neighbor sits one pixel back
	always_ff @(posedge clk) begin
		if (s1_adv && flags_s1.is_sample) begin
			dly_q[0] <= mid_rd;
			for (int k = 1; k < MAX_CHANNELS; k++) begin
				dly_q[k] <= dly_q[k-1];
			end
		end
	end

	assign left = dly_q[DIW'(cfg.chans - 1'b1)];

	always_comb begin
		centre5 = KW'(sh3_pkg::CENTRE_GAIN) * {4'b0, mid_rd};
		nsum    = {4'b0, left} + {4'b0, right_rd} + {4'b0, up_rd} + {4'b0, sample_s1};
		diff    = $signed(centre5) - $signed(nsum);
		if (diff[KW-1]) begin
			sat = '0;
		end else if (diff > $signed(KW'(255))) begin
			sat = '1;
		end else begin
			sat = diff[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= flags_s1.has_out;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && flags_s1.has_out) begin
			sharpened_q <= flags_s1.interior ? sat : '0;
			last_q      <= flags_s1.last;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.sharpened     = sharpened_q;
	assign out_ch.last_of_frame = last_q;

endmodule
